// File: src/rbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_pkg: shared constants and types for the RGBA blend compositor
// Fixed-point unit codes, blend mode codes and divider widths.
// ----------------------------------------------------------------------------
package rbc_pkg;

    localparam int unsigned UNIT  = 255;
    localparam int unsigned UNIT2 = UNIT * UNIT;
    localparam int unsigned UNIT3 = UNIT2 * UNIT;

    localparam int unsigned NUM_W  = 42;
    localparam int unsigned DEN_W  = 34;
    localparam int unsigned QUO_W  = 8;
    localparam int unsigned DIV_STAGES = QUO_W + 1;

    // alpha: floor((T + BIAS) / UNIT2) by reciprocal multiplication
    localparam int unsigned ALPHA_SHIFT = 40;
    localparam int unsigned ALPHA_BIAS  = (UNIT2 - 1) / 2;
    localparam longint unsigned ALPHA_RECIP =
        ((64'd1 << ALPHA_SHIFT) + 64'(UNIT2) - 64'd1) / 64'(UNIT2);

    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_MULTIPLY = 3'd1,
        MODE_SCREEN   = 3'd2,
        MODE_OVERLAY  = 3'd3,
        MODE_DARKEN   = 3'd4,
        MODE_LIGHTEN  = 3'd5
    } blend_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_MODE = 1'd0,
        REG_OPACITY    = 1'd1
    } cfg_reg_t;

endpackage
`default_nettype wire

// File: src/rbc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_if: pixel stream interfaces
// Input beat carries background and foreground RGBA8, output beat one RGBA8.
// ----------------------------------------------------------------------------
interface rbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] back_red;
    logic [7:0] back_green;
    logic [7:0] back_blue;
    logic [7:0] back_alpha;
    logic [7:0] fore_red;
    logic [7:0] fore_green;
    logic [7:0] fore_blue;
    logic [7:0] fore_alpha;

    modport source (output valid, back_red, back_green, back_blue, back_alpha,
                    fore_red, fore_green, fore_blue, fore_alpha, input ready);
    modport sink   (input valid, back_red, back_green, back_blue, back_alpha,
                    fore_red, fore_green, fore_blue, fore_alpha, output ready);
endinterface

interface rbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface
`default_nettype wire

// File: src/rbc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_div: pipelined restoring divider, one quotient bit per stage after the first
// Gives floor(num/den) clamped to 255, or 0 when the zero flag is set.
// ----------------------------------------------------------------------------
module rbc_div
    import rbc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic             zero,
    output logic      [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] rem_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];
    logic [QUO_W-1:0] q_reg   [DIV_STAGES];
    logic             ovf_reg [DIV_STAGES];
    logic             zero_reg[DIV_STAGES];

    logic [NUM_W-1:0] top_trial;

    assign top_trial = NUM_W'(den) << QUO_W;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= (num >= top_trial);
            zero_reg[0] <= zero;
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++)
    begin : g_step
        logic [NUM_W-1:0] trial;
        logic             fit;

        assign trial = NUM_W'(den_reg[k-1]) << (QUO_W - k);
        assign fit   = (rem_reg[k-1] >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= fit ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                q_reg[k]    <= q_reg[k-1] | (fit ? (QUO_W'(1) << (QUO_W - k)) : '0);
                ovf_reg[k]  <= ovf_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[DIV_STAGES-1])
            quo = '0;
        else if (ovf_reg[DIV_STAGES-1])
            quo = '1;
        else
            quo = q_reg[DIV_STAGES-1];
    end

endmodule
`default_nettype wire

// File: src/rgba_blend_composite.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_blend_composite: separable blend modes with source-over alpha
// Composites one foreground RGBA8 pixel over one background pixel per beat.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  pix_in    in   valid/ready      back_* and fore_* RGBA8
//  pix_out   out  valid/ready      out_* RGBA8
//  cfg       in   cfg_we           cfg_index, cfg_data
//
//  One beat in and one beat out per cycle while the output is not stalled;
//  four arithmetic stages and a nine-stage restoring divider per colour
//  channel; alpha by reciprocal multiply, delayed to match.
//  Reset clears the valid bits and loads blend_mode 0, opacity 255.
//  A stall at the output freezes every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rgba_blend_composite
    import rbc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    rbc_in_if.sink                    pix_in,
    rbc_out_if.source                 pix_out
);

    localparam int unsigned LAT = 4 + DIV_STAGES;

    logic [2:0] mode_reg;
    logic [7:0] opacity_reg;
    logic [LAT-1:0] valid_reg;
    logic advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            opacity_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLEND_MODE: mode_reg    <= cfg_data[2:0];
                REG_OPACITY:    opacity_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign advance      = !valid_reg[LAT-1] || pix_out.ready;
    assign pix_in.ready = advance;
    assign pix_out.valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[LAT-2:0], pix_in.valid};
    end

    // stage 1: opacity, blend and background products
    logic [7:0] back_c [3];
    logic [7:0] fore_c [3];
    logic [15:0] x_s1_reg  [3];
    logic [15:0] bb_s1_reg [3];
    logic [15:0] fa_s1_reg;
    logic [15:0] ba_s1_reg;
    logic [7:0]  bal_s1_reg;

    assign back_c[0] = pix_in.back_red;
    assign back_c[1] = pix_in.back_green;
    assign back_c[2] = pix_in.back_blue;
    assign fore_c[0] = pix_in.fore_red;
    assign fore_c[1] = pix_in.fore_green;
    assign fore_c[2] = pix_in.fore_blue;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fa_s1_reg  <= 16'(pix_in.fore_alpha) * 16'(opacity_reg);
            ba_s1_reg  <= {pix_in.back_alpha, 8'd0} - 16'(pix_in.back_alpha);
            bal_s1_reg <= pix_in.back_alpha;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_blend
        logic [15:0] pm;
        logic [15:0] ps;
        logic [7:0]  mn;
        logic [7:0]  mx;
        logic [15:0] x_next;

        assign pm = 16'(back_c[c]) * 16'(fore_c[c]);
        assign ps = 16'(8'd255 - back_c[c]) * 16'(8'd255 - fore_c[c]);
        assign mn = (back_c[c] < fore_c[c]) ? back_c[c] : fore_c[c];
        assign mx = (back_c[c] > fore_c[c]) ? back_c[c] : fore_c[c];

        always_comb
        begin
            case (mode_reg)
                MODE_MULTIPLY: x_next = pm;
                MODE_SCREEN:   x_next = 16'(UNIT2) - ps;
                MODE_OVERLAY:  x_next = (back_c[c] <= 8'd127) ? {pm[14:0], 1'b0}
                                                             : 16'(UNIT2) - {ps[14:0], 1'b0};
                MODE_DARKEN:   x_next = {mn, 8'd0} - 16'(mn);
                MODE_LIGHTEN:  x_next = {mx, 8'd0} - 16'(mx);
                default:       x_next = {fore_c[c], 8'd0} - 16'(fore_c[c]);
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_s1_reg[c]  <= x_next;
                bb_s1_reg[c] <= 16'(back_c[c]) * 16'(pix_in.back_alpha);
            end
        end
    end

    // stage 2: weight by foreground alpha and its complement
    logic [15:0] inv_s2;
    logic [31:0] xf_s2_reg [3];
    logic [31:0] bi_s2_reg [3];
    logic [31:0] oaa_s2_reg;
    logic [31:0] oab_s2_reg;
    logic [23:0] ta_s2_reg;
    logic [23:0] tb_s2_reg;

    assign inv_s2 = 16'(UNIT2) - fa_s1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            oaa_s2_reg <= 32'(fa_s1_reg) * 32'(UNIT2);
            oab_s2_reg <= 32'(ba_s1_reg) * 32'(inv_s2);
            ta_s2_reg  <= {fa_s1_reg, 8'd0} - 24'(fa_s1_reg);
            tb_s2_reg  <= 24'(bal_s1_reg) * 24'(inv_s2);
            for (int c = 0; c < 3; c++)
            begin
                xf_s2_reg[c] <= 32'(x_s1_reg[c]) * 32'(fa_s1_reg);
                bi_s2_reg[c] <= 32'(bb_s1_reg[c]) * 32'(inv_s2);
            end
        end
    end

    // stage 3: sums
    logic [31:0] n_s3_reg [3];
    logic [31:0] oa_s3_reg;
    logic [23:0] m_s3_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            oa_s3_reg <= oaa_s2_reg + oab_s2_reg;
            m_s3_reg  <= ta_s2_reg + tb_s2_reg + 24'(ALPHA_BIAS);
            for (int c = 0; c < 3; c++)
                n_s3_reg[c] <= xf_s2_reg[c] + bi_s2_reg[c];
        end
    end

    // stage 4: dividend and divisor for each colour lane, alpha quotient
    logic [NUM_W-1:0] num_s4_reg [3];
    logic [DEN_W-1:0] den_s4_reg [3];
    logic             zero_s4_reg;
    logic [QUO_W-1:0] quo [3];
    logic [47:0]      alpha_prod;
    logic [7:0]       alpha_s4_reg;
    logic [7:0]       alpha_dly_reg [DIV_STAGES];

    assign alpha_prod = 48'(m_s3_reg) * 48'(ALPHA_RECIP);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < 3; c++)
            begin
                num_s4_reg[c] <= (NUM_W'(n_s3_reg[c]) << 9) - (NUM_W'(n_s3_reg[c]) << 1)
                                 + NUM_W'(oa_s3_reg);
                den_s4_reg[c] <= {1'b0, oa_s3_reg, 1'b0};
            end
            alpha_s4_reg <= alpha_prod[ALPHA_SHIFT +: 8];
            zero_s4_reg  <= (oa_s3_reg == '0);
        end
    end

    // alpha rides alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            alpha_dly_reg[0] <= alpha_s4_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                alpha_dly_reg[k] <= alpha_dly_reg[k-1];
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        rbc_div u_div (
            .clk  (clk),
            .en   (advance),
            .num  (num_s4_reg[c]),
            .den  (den_s4_reg[c]),
            .zero (zero_s4_reg),
            .quo  (quo[c])
        );
    end

    assign pix_out.out_red   = quo[0];
    assign pix_out.out_green = quo[1];
    assign pix_out.out_blue  = quo[2];
    assign pix_out.out_alpha = alpha_dly_reg[DIV_STAGES-1];

`ifndef SYNTH
    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && !pix_out.ready) |-> !pix_in.ready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready) |=> valid_reg[0])
        else $error("accepted beat lost at stage 1");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
